FILE: rtl/lrsg_pkg.sv
package lrsg_pkg;

	localparam int MAX_BEAMS   = 1024;
	localparam int BEAM_AW     = $clog2(MAX_BEAMS);
	localparam int MAX_HISTORY = 8;
	localparam int HIST_SLOTS  = MAX_HISTORY - 1;
	localparam int SLOT_W      = $clog2(HIST_SLOTS);
	localparam int RANGE_W     = 16;
	localparam int HIST_W      = RANGE_W * HIST_SLOTS;
	localparam int SUM_W       = RANGE_W + $clog2(MAX_HISTORY);
	localparam int TRIG_W      = 16;
	localparam int LIM_W       = RANGE_W + 4;
	localparam int PROD_W      = SUM_W + 1 + TRIG_W;
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int QW_LAST     = 256;

	localparam logic [2:0] REG_SAFE_DIST  = 3'd0;
	localparam logic [2:0] REG_BEAM_STEP  = 3'd1;
	localparam logic [2:0] REG_HIST_LEN   = 3'd2;
	localparam logic [2:0] REG_FACING_FWD = 3'd3;
	localparam logic [2:0] REG_BOX_MODE   = 3'd4;
	localparam logic [2:0] REG_BOX_HALF   = 3'd5;
	localparam logic [2:0] REG_START_ANG  = 3'd6;
	localparam logic [2:0] REG_ANGLE_INC  = 3'd7;

	localparam logic REQ_RANGE   = 1'b0;
	localparam logic REQ_COMMAND = 1'b1;

	typedef struct packed {
		logic [15:0] safe_distance_mm;
		logic [10:0] beam_step;
		logic [3:0]  history_length;
		logic        facing_forward;
		logic        box_mode;
		logic [15:0] box_half_width_mm;
		logic [15:0] start_angle;
		logic [11:0] angle_increment;
	} cfg_t;

	typedef struct packed {
		logic        hist_len;
		logic        beam_step;
		logic        start_angle;
		logic [15:0] start_value;
	} cfg_wr_t;

	typedef struct packed {
		logic                      req_type;
		logic [RANGE_W-1:0]        range_mm;
		logic                      last;
		logic                      away;
		logic                      check;
		logic [BEAM_AW-1:0]        addr;
		logic signed [TRIG_W-1:0]  sin_v;
		logic signed [TRIG_W-1:0]  cos_v;
	} q_entry_t;

	typedef logic [QW_LAST:0][15:0] qw_tab_t;

	function automatic qw_tab_t build_qw();
		qw_tab_t tab;
		longint t;
		longint t2;
		longint r;
		longint s;
		for (int i = 0; i <= QW_LAST; i++) begin
			t  = longint'(i) * 128;
			t2 = (t * t) >>> 15;
			r  = 21051 - ((t2 * 2386) >>> 15);
			r  = 51472 - ((t2 * r) >>> 15);
			s  = (t * r) >>> 15;
			if (s > 32767) begin
				s = 32767;
			end
			tab[i] = s[15:0];
		end
		return tab;
	endfunction

	localparam qw_tab_t QW_TAB = build_qw();

	function automatic logic signed [TRIG_W-1:0] sin_lookup(logic [15:0] a);
		logic [9:0]  idx;
		logic [8:0]  j;
		logic [15:0] v;
		idx = a[15:6];
		j   = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
		v   = QW_TAB[j];
		return idx[9] ? -signed'(v) : signed'(v);
	endfunction

endpackage

FILE: rtl/lrsg_ram.sv
module lrsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/lrsg_queue.sv
module lrsg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lrsg_pkg::q_entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output lrsg_pkg::q_entry_t  head_entry
);

	lrsg_pkg::q_entry_t          slot_q [lrsg_pkg::QDEPTH];
	logic [lrsg_pkg::QAW-1:0]    wptr_q;
	logic [lrsg_pkg::QAW-1:0]    rptr_q;
	logic [lrsg_pkg::QAW:0]      count_q;

	assign full       = (count_q == (lrsg_pkg::QAW+1)'(lrsg_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/lrsg_front.sv
module lrsg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [15:0]         range_mm,
	input  logic                last_of_scan,
	input  logic                forward_motion,
	input  lrsg_pkg::cfg_t      cfg,
	input  lrsg_pkg::cfg_wr_t   cfg_wr,
	input  logic                back_busy,
	input  logic                q_full,
	output logic                q_push,
	output lrsg_pkg::q_entry_t  q_entry
);

	logic [lrsg_pkg::BEAM_AW:0] beam_index_q;
	logic [15:0]                beam_angle_q;
	logic [10:0]                step_cnt_q;
	logic                       rem_busy_q;
	logic [3:0]                 rem_bit_q;
	logic [10:0]                rem_q;
	logic [10:0]                rem_try;
	logic [10:0]                rem_next;
	logic [10:0]                step_inc;
	logic                       is_range;

	assign in_stall = q_full || back_busy || rem_busy_q || cfg_wr.beam_step || cfg_wr.hist_len;
	assign q_push   = in_valid && !in_stall;
	assign is_range = (req_type == lrsg_pkg::REQ_RANGE);
	assign step_inc = step_cnt_q + 11'd1;

	always_comb begin
		rem_try  = {rem_q[9:0], beam_index_q[rem_bit_q]};
		rem_next = (rem_try >= cfg.beam_step) ? rem_try - cfg.beam_step : rem_try;
	end

	always_comb begin
		q_entry.req_type = req_type;
		q_entry.range_mm = range_mm;
		q_entry.last     = last_of_scan;
		q_entry.away     = cfg.facing_forward ? !forward_motion : forward_motion;
		q_entry.check    = !beam_index_q[lrsg_pkg::BEAM_AW] && (step_cnt_q == '0);
		q_entry.addr     = beam_index_q[lrsg_pkg::BEAM_AW-1:0];
		q_entry.sin_v    = lrsg_pkg::sin_lookup(beam_angle_q);
		q_entry.cos_v    = lrsg_pkg::sin_lookup(beam_angle_q + 16'd16384);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_index_q <= '0;
			beam_angle_q <= 16'hC000;
			step_cnt_q   <= '0;
			rem_busy_q   <= 1'b0;
			rem_bit_q    <= '0;
			rem_q        <= '0;
		end else begin
			if (cfg_wr.start_angle && (beam_index_q == '0)) begin
				beam_angle_q <= cfg_wr.start_value;
			end
			if (cfg_wr.beam_step) begin
				rem_busy_q <= 1'b1;
				rem_bit_q  <= 4'd9;
				rem_q      <= '0;
			end else if (rem_busy_q) begin
				rem_q     <= rem_next;
				rem_bit_q <= rem_bit_q - 4'd1;
				if (rem_bit_q == '0) begin
					rem_busy_q <= 1'b0;
					step_cnt_q <= rem_next;
				end
			end
			if (q_push && is_range) begin
				if (last_of_scan) begin
					beam_index_q <= '0;
					beam_angle_q <= cfg.start_angle;
					step_cnt_q   <= '0;
				end else begin
					if (!beam_index_q[lrsg_pkg::BEAM_AW]) begin
						beam_index_q <= beam_index_q + 1'b1;
					end
					beam_angle_q <= beam_angle_q + {4'd0, cfg.angle_increment};
					step_cnt_q   <= (step_inc >= cfg.beam_step) ? '0 : step_inc;
				end
			end
		end
	end

endmodule

FILE: rtl/lrsg_back.sv
module lrsg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lrsg_pkg::cfg_t      cfg,
	input  lrsg_pkg::cfg_wr_t   cfg_wr,
	input  logic                q_valid,
	input  lrsg_pkg::q_entry_t  q_entry,
	output logic                q_pop,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic                blocked,
	output logic                pass_command
);

	logic                                  adv;
	logic                                  clr_busy_q;
	logic [lrsg_pkg::BEAM_AW-1:0]          clr_addr_q;
	logic [lrsg_pkg::SLOT_W-1:0]           slot_q;
	logic [lrsg_pkg::SLOT_W-1:0]           slot_inc;
	logic [3:0]                            hl_m1;
	logic                                  fwd_q;
	logic [lrsg_pkg::HIST_W-1:0]           fwd_data_q;
	logic [lrsg_pkg::HIST_W-1:0]           rdata;
	logic [lrsg_pkg::HIST_W-1:0]           word;
	logic [lrsg_pkg::HIST_W-1:0]           merged;
	logic [lrsg_pkg::HIST_W-1:0]           ram_wdata;
	logic [lrsg_pkg::BEAM_AW-1:0]          ram_waddr;
	logic                                  ram_we;
	logic                                  item_we;
	logic [lrsg_pkg::SUM_W-1:0]            sum;

	logic                                  valid_s1;
	lrsg_pkg::q_entry_t                    entry_s1;

	logic                                  valid_s2;
	logic                                  req_s2;
	logic                                  last_s2;
	logic                                  away_s2;
	logic                                  check_s2;
	logic [lrsg_pkg::SUM_W-1:0]            sum_s2;
	logic signed [lrsg_pkg::TRIG_W-1:0]    sin_s2;
	logic signed [lrsg_pkg::TRIG_W-1:0]    cos_s2;

	logic                                  valid_s3;
	logic                                  req_s3;
	logic                                  last_s3;
	logic                                  away_s3;
	logic                                  check_s3;
	logic [lrsg_pkg::SUM_W-1:0]            sum_s3;
	logic signed [lrsg_pkg::PROD_W-1:0]    x_s3;
	logic signed [lrsg_pkg::PROD_W-1:0]    y_s3;
	logic [lrsg_pkg::LIM_W-1:0]            safe_lim_s3;
	logic [lrsg_pkg::LIM_W-1:0]            half_lim_s3;

	logic signed [lrsg_pkg::PROD_W-1:0]    y_abs;
	logic                                  hit;
	logic                                  scan_hit_q;
	logic                                  blocked_q;
	logic                                  out_valid_q;
	logic                                  kind_q;
	logic                                  blk_q;
	logic                                  pass_q;

	assign adv      = !(out_valid_q && out_stall);
	assign q_pop    = adv && q_valid && !clr_busy_q;
	assign busy     = clr_busy_q;
	assign hl_m1    = cfg.history_length - 4'd1;
	assign slot_inc = slot_q + 1'b1;

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign blocked      = blk_q;
	assign pass_command = pass_q;

	always_comb begin
		word = fwd_q ? fwd_data_q : rdata;
		sum  = lrsg_pkg::SUM_W'(entry_s1.range_mm);
		for (int j = 0; j < lrsg_pkg::HIST_SLOTS; j++) begin
			if (4'(j) < hl_m1) begin
				sum = sum + lrsg_pkg::SUM_W'(word[j*lrsg_pkg::RANGE_W +: lrsg_pkg::RANGE_W]);
			end
		end
		merged = word;
		merged[slot_q*lrsg_pkg::RANGE_W +: lrsg_pkg::RANGE_W] = entry_s1.range_mm;
	end

	assign item_we   = adv && valid_s1 && (entry_s1.req_type == lrsg_pkg::REQ_RANGE)
		&& entry_s1.check && (cfg.history_length > 4'd1);
	assign ram_we    = clr_busy_q || item_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : entry_s1.addr;
	assign ram_wdata = clr_busy_q ? '0 : merged;

	lrsg_ram #(
		.WIDTH(lrsg_pkg::HIST_W),
		.DEPTH(lrsg_pkg::MAX_BEAMS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_entry.addr),
		.rdata (rdata)
	);

	always_comb begin
		y_abs = (y_s3 < 0) ? -y_s3 : y_s3;
		if (cfg.box_mode) begin
			hit = check_s3
				&& (x_s3 < signed'({1'b0, safe_lim_s3, 15'd0}))
				&& (y_abs < signed'({1'b0, half_lim_s3, 15'd0}));
		end else begin
			hit = check_s3 && (lrsg_pkg::LIM_W'(sum_s3) < safe_lim_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_data_q  <= merged;
			entry_s1    <= q_entry;
			req_s2      <= entry_s1.req_type;
			last_s2     <= entry_s1.last;
			away_s2     <= entry_s1.away;
			check_s2    <= entry_s1.check;
			sum_s2      <= sum;
			sin_s2      <= entry_s1.sin_v;
			cos_s2      <= entry_s1.cos_v;
			req_s3      <= req_s2;
			last_s3     <= last_s2;
			away_s3     <= away_s2;
			check_s3    <= check_s2;
			sum_s3      <= sum_s2;
			x_s3        <= lrsg_pkg::PROD_W'(signed'({1'b0, sum_s2}))
				* lrsg_pkg::PROD_W'(cos_s2);
			y_s3        <= lrsg_pkg::PROD_W'(signed'({1'b0, sum_s2}))
				* lrsg_pkg::PROD_W'(sin_s2);
			safe_lim_s3 <= lrsg_pkg::LIM_W'(cfg.safe_distance_mm)
				* lrsg_pkg::LIM_W'(cfg.history_length);
			half_lim_s3 <= lrsg_pkg::LIM_W'(cfg.box_half_width_mm)
				* lrsg_pkg::LIM_W'(cfg.history_length);
			kind_q      <= req_s3;
			blk_q       <= req_s3 ? blocked_q : (scan_hit_q || hit);
			pass_q      <= req_s3 && (!blocked_q || away_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			slot_q      <= '0;
			fwd_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			scan_hit_q  <= 1'b0;
			blocked_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr.hist_len) begin
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == lrsg_pkg::BEAM_AW'(lrsg_pkg::MAX_BEAMS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_wr.hist_len) begin
				slot_q <= '0;
			end else if (adv && valid_s1 && (entry_s1.req_type == lrsg_pkg::REQ_RANGE)
				&& entry_s1.last) begin
				if ((cfg.history_length > 4'd1) && (4'(slot_inc) != hl_m1)) begin
					slot_q <= slot_inc;
				end else begin
					slot_q <= '0;
				end
			end
			if (adv) begin
				fwd_q       <= q_pop && item_we && (q_entry.addr == entry_s1.addr);
				valid_s1    <= q_pop;
				valid_s2    <= valid_s1;
				valid_s3    <= valid_s2;
				out_valid_q <= valid_s3 && (req_s3 || last_s3);
				if (valid_s3 && (req_s3 == lrsg_pkg::REQ_RANGE)) begin
					if (last_s3) begin
						blocked_q  <= scan_hit_q || hit;
						scan_hit_q <= 1'b0;
					end else if (hit) begin
						scan_hit_q <= 1'b1;
					end
				end
			end
		end
	end

`ifndef SYNTH
	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !q_pop)
		else $error("history item issued during clearing pass");
	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> valid_s1)
		else $error("history bypass active without an item in s1");
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q == '0) || (4'(slot_q) < hl_m1))
		else $error("history slot beyond the configured length");
`endif

endmodule

FILE: rtl/laser_range_safety_guard_core.sv
// Laser range safety guard. Range samples and motion commands share one input channel and
// are answered in order: the last sample of a scan returns the scan verdict, a command
// returns whether it passes, other samples return nothing. One request is taken per cycle
// while in_stall is low; a four-entry queue between the classifying front end and the
// checking pipeline absorbs output stalls. After reset and after every write of
// history_length, the 1024-row history memory is cleared one row per cycle, and no request
// is taken until the clear is done. After a write of beam_step the input stalls while the
// beam phase of the current scan is recomputed.
module laser_range_safety_guard_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [15:0] range_mm,
	input  logic        last_of_scan,
	input  logic        forward_motion,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic        blocked,
	output logic        pass_command
);

	lrsg_pkg::cfg_t     cfg_q;
	lrsg_pkg::cfg_wr_t  cfg_wr;
	lrsg_pkg::q_entry_t push_entry;
	lrsg_pkg::q_entry_t head_entry;
	logic               wr_en;
	logic [2:0]         reg_sel;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               head_valid;
	logic               back_busy;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		cfg_wr.hist_len    = wr_en && (reg_sel == lrsg_pkg::REG_HIST_LEN);
		cfg_wr.beam_step   = wr_en && (reg_sel == lrsg_pkg::REG_BEAM_STEP);
		cfg_wr.start_angle = wr_en && (reg_sel == lrsg_pkg::REG_START_ANG);
		cfg_wr.start_value = pwdata[15:0];
	end

	always_comb begin
		case (reg_sel)
			lrsg_pkg::REG_SAFE_DIST:  prdata = {16'd0, cfg_q.safe_distance_mm};
			lrsg_pkg::REG_BEAM_STEP:  prdata = {21'd0, cfg_q.beam_step};
			lrsg_pkg::REG_HIST_LEN:   prdata = {28'd0, cfg_q.history_length};
			lrsg_pkg::REG_FACING_FWD: prdata = {31'd0, cfg_q.facing_forward};
			lrsg_pkg::REG_BOX_MODE:   prdata = {31'd0, cfg_q.box_mode};
			lrsg_pkg::REG_BOX_HALF:   prdata = {16'd0, cfg_q.box_half_width_mm};
			lrsg_pkg::REG_START_ANG:  prdata = {{16{cfg_q.start_angle[15]}}, cfg_q.start_angle};
			lrsg_pkg::REG_ANGLE_INC:  prdata = {20'd0, cfg_q.angle_increment};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.safe_distance_mm  <= 16'd400;
			cfg_q.beam_step         <= 11'd5;
			cfg_q.history_length    <= 4'd1;
			cfg_q.facing_forward    <= 1'b1;
			cfg_q.box_mode          <= 1'b1;
			cfg_q.box_half_width_mm <= 16'd0;
			cfg_q.start_angle       <= 16'hC000;
			cfg_q.angle_increment   <= 12'd182;
		end else if (wr_en) begin
			case (reg_sel)
				lrsg_pkg::REG_SAFE_DIST:  cfg_q.safe_distance_mm <= pwdata[15:0];
				lrsg_pkg::REG_BEAM_STEP: begin
					cfg_q.beam_step <= (pwdata[10:0] == '0) ? 11'd1 : pwdata[10:0];
				end
				lrsg_pkg::REG_HIST_LEN: begin
					if (pwdata[3:0] == '0) begin
						cfg_q.history_length <= 4'd1;
					end else if (pwdata[3:0] > 4'(lrsg_pkg::MAX_HISTORY)) begin
						cfg_q.history_length <= 4'(lrsg_pkg::MAX_HISTORY);
					end else begin
						cfg_q.history_length <= pwdata[3:0];
					end
				end
				lrsg_pkg::REG_FACING_FWD: cfg_q.facing_forward    <= pwdata[0];
				lrsg_pkg::REG_BOX_MODE:   cfg_q.box_mode          <= pwdata[0];
				lrsg_pkg::REG_BOX_HALF:   cfg_q.box_half_width_mm <= pwdata[15:0];
				lrsg_pkg::REG_START_ANG:  cfg_q.start_angle       <= pwdata[15:0];
				lrsg_pkg::REG_ANGLE_INC:  cfg_q.angle_increment   <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	lrsg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.range_mm       (range_mm),
		.last_of_scan   (last_of_scan),
		.forward_motion (forward_motion),
		.cfg            (cfg_q),
		.cfg_wr         (cfg_wr),
		.back_busy      (back_busy),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (push_entry)
	);

	lrsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lrsg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_wr       (cfg_wr),
		.q_valid      (head_valid),
		.q_entry      (head_entry),
		.q_pop        (q_pop),
		.busy         (back_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.blocked      (blocked),
		.pass_command (pass_command)
	);

endmodule
